// ----- hdl/rluc_pkg.sv -----
package rluc_pkg;

  // Bitmap capacity and derived widths
  localparam int WINDOW_MAX = 4096;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = IDX_W + 1;
  localparam int VALUE_BITS = 32;

  // Character codes of the range list
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2
  } rluc_op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_SETUP,
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP,
    ST_MARK_SETUP,
    ST_MARK,
    ST_CNT_SETUP,
    ST_COUNT,
    ST_COUNT_TAIL,
    ST_EMIT
  } rluc_state_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]            op;
    logic [7:0]            ch;
    logic [VALUE_BITS-1:0] window_low;
    logic [VALUE_BITS-1:0] window_high;
  } rluc_in_t;

  // Result transaction
  typedef struct packed {
    logic [VALUE_BITS-1:0] unread_count;
    logic                  window_too_wide;
  } rluc_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_win;
    logic setup;
    logic take_char;
    logic clip;
    logic mark_setup;
    logic cnt_start;
    logic clear_parser;
    logic mem_clr;
    logic mem_mark;
    logic mem_rd;
    logic load_out;
  } rluc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fits;
    logic seg_open;
    logic is_delim;
    logic mark_ok;
    logic sweep_needed;
    logic at_last;
    logic out_free;
  } rluc_status_t;

endpackage

// ----- hdl/rluc_ram.sv -----
module rluc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rluc_ctrl.sv -----
module rluc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_op_i,
  input  rluc_pkg::rluc_status_t status_i,
  output rluc_pkg::rluc_cmd_t    cmd_o,
  output logic                   in_stall_o
);

  rluc_pkg::rluc_state_e state_q, state_d;
  logic                  end_pend_q, end_pend_d;
  logic                  accept;

  assign in_stall_o = (state_q != rluc_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == rluc_pkg::ST_IDLE);

  // Hold state; reset enters window setup so that entry 0 is cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rluc_pkg::ST_SETUP;
      end_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_pend_q <= end_pend_d;
    end
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    end_pend_d = end_pend_q;
    unique case (state_q)
      rluc_pkg::ST_SETUP: state_d = rluc_pkg::ST_CLEAR;
      rluc_pkg::ST_CLEAR: begin
        if (!status_i.fits || status_i.at_last) state_d = rluc_pkg::ST_IDLE;
      end
      rluc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op_i)
            rluc_pkg::OP_BEGIN: state_d = rluc_pkg::ST_SETUP;
            rluc_pkg::OP_CHAR: begin
              end_pend_d = 1'b0;
              if (status_i.is_delim) state_d = rluc_pkg::ST_CLIP;
            end
            rluc_pkg::OP_END: begin
              end_pend_d = 1'b1;
              state_d = status_i.seg_open ? rluc_pkg::ST_CLIP : rluc_pkg::ST_CNT_SETUP;
            end
            default: state_d = rluc_pkg::ST_IDLE;
          endcase
        end
      end
      rluc_pkg::ST_CLIP: state_d = rluc_pkg::ST_MARK_SETUP;
      rluc_pkg::ST_MARK_SETUP: begin
        if (status_i.mark_ok) begin
          state_d = rluc_pkg::ST_MARK;
        end else begin
          state_d = end_pend_q ? rluc_pkg::ST_CNT_SETUP : rluc_pkg::ST_IDLE;
        end
      end
      rluc_pkg::ST_MARK: begin
        if (status_i.at_last) begin
          state_d = end_pend_q ? rluc_pkg::ST_CNT_SETUP : rluc_pkg::ST_IDLE;
        end
      end
      rluc_pkg::ST_CNT_SETUP: begin
        state_d = status_i.sweep_needed ? rluc_pkg::ST_COUNT : rluc_pkg::ST_EMIT;
      end
      rluc_pkg::ST_COUNT: begin
        if (status_i.at_last) state_d = rluc_pkg::ST_COUNT_TAIL;
      end
      rluc_pkg::ST_COUNT_TAIL: state_d = rluc_pkg::ST_EMIT;
      rluc_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = rluc_pkg::ST_IDLE;
      end
      default: state_d = rluc_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      rluc_pkg::ST_SETUP: cmd_o.setup = 1'b1;
      rluc_pkg::ST_CLEAR: cmd_o.mem_clr = status_i.fits;
      rluc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op_i)
            rluc_pkg::OP_BEGIN: begin
              cmd_o.load_win     = 1'b1;
              cmd_o.clear_parser = 1'b1;
            end
            rluc_pkg::OP_CHAR: cmd_o.take_char = 1'b1;
            default: cmd_o = '0;
          endcase
        end
      end
      rluc_pkg::ST_CLIP: cmd_o.clip = 1'b1;
      rluc_pkg::ST_MARK_SETUP: begin
        cmd_o.mark_setup   = 1'b1;
        cmd_o.clear_parser = 1'b1;
      end
      rluc_pkg::ST_MARK: cmd_o.mem_mark = 1'b1;
      rluc_pkg::ST_CNT_SETUP: begin
        cmd_o.cnt_start    = 1'b1;
        cmd_o.clear_parser = 1'b1;
      end
      rluc_pkg::ST_COUNT: cmd_o.mem_rd = 1'b1;
      rluc_pkg::ST_COUNT_TAIL: cmd_o = '0;
      rluc_pkg::ST_EMIT: cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/rluc_dp.sv -----
module rluc_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rluc_pkg::rluc_in_t     in_data_i,
  input  rluc_pkg::rluc_cmd_t    cmd_i,
  output rluc_pkg::rluc_status_t status_o,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rluc_pkg::rluc_out_t    out_data_o
);

  localparam int VB = rluc_pkg::VALUE_BITS;
  localparam int IW = rluc_pkg::IDX_W;
  localparam int CW = rluc_pkg::CNT_W;

  logic [VB-1:0] win_low_q, win_high_q, diff_q;
  logic          ordered_q, fits_q, ignore_q;
  logic [VB-1:0] digit_q, seg_low_q;
  logic          saw_hyph_q, seg_open_q;
  logic [VB-1:0] lo_c_q, hi_c_q;
  logic          ok_q;
  logic [IW-1:0] idx_q, last_q;
  logic [CW-1:0] cnt_q;
  logic          rd_vld_q;
  logic          out_valid_q;
  rluc_pkg::rluc_out_t out_q, out_d;

  logic [VB-1:0] diff;
  logic [VB+3:0] dig_prod;
  logic [VB-1:0] dig_next;
  logic [VB-1:0] seg_hi, seg_lo;
  logic [VB-1:0] lo_off, hi_off;
  logic          is_digit, is_delim;
  logic          mem_we, mem_wdata, mem_rdata;
  logic [IW-1:0] mem_addr;

  // Character classes and saturating decimal accumulate
  assign is_digit = (in_data_i.ch >= rluc_pkg::CH_ZERO) && (in_data_i.ch <= rluc_pkg::CH_NINE);
  assign is_delim = (in_data_i.ch == rluc_pkg::CH_SPACE) || (in_data_i.ch == rluc_pkg::CH_COMMA)
                 || (in_data_i.ch == rluc_pkg::CH_NL);
  assign dig_prod = ({4'b0, digit_q} << 3) + ({4'b0, digit_q} << 1)
                  + {{VB{1'b0}}, in_data_i.ch[3:0]};
  assign dig_next = (|dig_prod[VB+3:VB]) ? '1 : dig_prod[VB-1:0];

  // Window extent and segment bounds
  assign diff   = win_high_q - win_low_q;
  assign seg_hi = digit_q;
  assign seg_lo = saw_hyph_q ? seg_low_q : digit_q;
  assign lo_off = lo_c_q - win_low_q;
  assign hi_off = hi_c_q - win_low_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_q <= 1'b0;
    end else if (cfg_valid_i) begin
      ignore_q <= cfg_data_i;
    end
  end

  // Window registers and derived flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= '0;
      win_high_q <= '0;
      diff_q     <= '0;
      ordered_q  <= 1'b1;
      fits_q     <= 1'b1;
    end else begin
      if (cmd_i.load_win) begin
        win_low_q  <= in_data_i.window_low;
        win_high_q <= in_data_i.window_high;
      end
      if (cmd_i.setup) begin
        diff_q    <= diff;
        ordered_q <= (win_low_q <= win_high_q);
        fits_q    <= (win_low_q <= win_high_q) && (diff < VB'(rluc_pkg::WINDOW_MAX));
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q    <= '0;
      seg_low_q  <= '0;
      saw_hyph_q <= 1'b0;
      seg_open_q <= 1'b0;
    end else if (cmd_i.clear_parser) begin
      digit_q    <= '0;
      seg_low_q  <= '0;
      saw_hyph_q <= 1'b0;
      seg_open_q <= 1'b0;
    end else if (cmd_i.take_char) begin
      if (is_digit) begin
        digit_q    <= dig_next;
        seg_open_q <= 1'b1;
      end else if (in_data_i.ch == rluc_pkg::CH_HYPHEN) begin
        seg_low_q  <= digit_q;
        digit_q    <= '0;
        saw_hyph_q <= 1'b1;
        seg_open_q <= 1'b1;
      end
    end
  end

  // Clip the segment to the window
  always_ff @(posedge clk_i) begin
    if (cmd_i.clip) begin
      ok_q   <= fits_q && !((seg_hi < win_low_q) || (seg_lo > win_high_q));
      hi_c_q <= (seg_hi > win_high_q) ? win_high_q : seg_hi;
      lo_c_q <= (seg_lo < win_low_q) ? win_low_q : seg_lo;
    end
  end

  // Sweep index over the bitmap
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.setup) begin
      idx_q  <= '0;
      last_q <= diff[IW-1:0];
    end else if (cmd_i.mark_setup) begin
      idx_q  <= lo_off[IW-1:0];
      last_q <= hi_off[IW-1:0];
    end else if (cmd_i.cnt_start) begin
      idx_q  <= '0;
      last_q <= diff_q[IW-1:0];
    end else if (cmd_i.mem_clr || cmd_i.mem_mark || cmd_i.mem_rd) begin
      idx_q <= idx_q + 1'b1;
    end else begin
      idx_q  <= idx_q;
      last_q <= last_q;
    end
  end

  // Count unmarked entries one read behind the address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.mem_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_start) begin
      cnt_q <= '0;
    end else if (rd_vld_q && !mem_rdata) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Coverage bitmap
  assign mem_we    = cmd_i.mem_clr || cmd_i.mem_mark;
  assign mem_wdata = cmd_i.mem_mark;
  assign mem_addr  = idx_q;

  rluc_ram #(
    .WIDTH (1),
    .DEPTH (rluc_pkg::WINDOW_MAX)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Form the result
  always_comb begin
    out_d = '0;
    priority if (!ordered_q) begin
      out_d = '0;
    end else if (ignore_q) begin
      out_d.unread_count = diff_q;
    end else if (!fits_q) begin
      out_d.window_too_wide = 1'b1;
    end else begin
      out_d.unread_count[CW-1:0] = cnt_q;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status
  assign status_o.fits         = fits_q;
  assign status_o.seg_open     = seg_open_q;
  assign status_o.is_delim     = is_delim;
  assign status_o.mark_ok      = ok_q && (lo_c_q <= hi_c_q);
  assign status_o.sweep_needed = ordered_q && !ignore_q && fits_q;
  assign status_o.at_last      = (idx_q == last_q);
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

endmodule

// ----- hdl/range_list_unread_counter.sv -----
// Range list unread counter.
// Input channel (in_valid_i / in_stall_o, payload in_data_i) takes begin,
// character and end transactions; a transaction is taken when valid is high
// and stall is low. Output channel (out_valid_o / out_stall_i) gives one
// result, unread_count and window_too_wide, for each end transaction.
// Configuration channel (cfg_valid_i / cfg_ready_o) is always ready; the user
// must write ignore_ranges only while the block is idle; this is unchecked.
// Transaction steps, set by the single port of the coverage bitmap:
//   character: added to the parser; a delimiter then clips the segment and
//   marks its clipped numbers entry by entry if it overlaps the window
//   begin: setup, then clearing of each window entry if the window fits
//   end: clip and mark of an open segment, count setup, then a count sweep
//   and tail if the window fits and ignore mode is off, then the result
// Reset leaves a window of 0..0 and clears bitmap entry 0 before the first
// transaction is taken. A result waits in the output register while the
// receiver stalls; transactions are taken until the next result waits on it.
module range_list_unread_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rluc_pkg::rluc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rluc_pkg::rluc_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  rluc_pkg::rluc_cmd_t    cmd;
  rluc_pkg::rluc_status_t status;

  assign cfg_ready_o = 1'b1;

  rluc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rluc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
